// ----- rtl/core/hid6_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid6_pkg
// Shared types and constants for the six-key keyboard report builder.
// ----------------------------------------------------------------------------
package hid6_pkg;

    localparam int SLOTS          = 6;
    localparam int KEY_W          = 8;
    localparam int KEY_CODES      = 256;
    localparam int MOD_BITS       = 8;
    localparam int MOD_IDX_W      = 3;
    localparam int COUNT_WIDTH_DEF = 8;

    // event codes
    localparam logic [1:0] MODE_KEY_PRESS   = 2'd0;
    localparam logic [1:0] MODE_KEY_RELEASE = 2'd1;
    localparam logic [1:0] MODE_MOD_PRESS   = 2'd2;
    localparam logic [1:0] MODE_MOD_RELEASE = 2'd3;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [SLOTS-1:0][KEY_W-1:0] t_list;

    // one update request for the pressed key list
    typedef struct packed {
        logic press;
        logic remove;
        t_key code;
    } t_list_cmd;

endpackage

// ----- rtl/core/hid6_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid6_list
// Ordered six-slot list of pressed keys: append, drop-oldest when full,
// and remove with shift-down of the later slots.
// ----------------------------------------------------------------------------
module hid6_list (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hid6_pkg::t_list_cmd i_cmd,
    output hid6_pkg::t_list   o_list
);
    import hid6_pkg::*;

    t_list r_list;
    t_list n_list;
    t_list w_shift;
    logic  w_done;
    logic  w_seen;

    // slot i takes slot i+1, top slot cleared to zero
    assign w_shift = t_list'({{KEY_W{1'b0}}, r_list[SLOTS-1:1]});

    always_comb begin
        n_list = r_list;
        w_done = 1'b0;
        w_seen = 1'b0;
        if (i_cmd.press) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!w_done) begin
                    if (r_list[i] == i_cmd.code) begin
                        w_done = 1'b1;
                    end else if (r_list[i] == '0) begin
                        n_list[i] = i_cmd.code;
                        w_done    = 1'b1;
                    end
                end
            end
            // full list: drop the oldest, append at the end
            if (!w_done) begin
                n_list          = w_shift;
                n_list[SLOTS-1] = i_cmd.code;
            end
        end else if (i_cmd.remove) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_list[i] == i_cmd.code) begin
                    w_seen = 1'b1;
                end
                if (w_seen) begin
                    n_list[i] = w_shift[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list <= '0;
        end else begin
            r_list <= n_list;
        end
    end

    assign o_list = r_list;

endmodule

// ----- rtl/core/hid_six_key_report_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_six_key_report_builder_unit
// Boot keyboard report builder: per-key and per-modifier press counts,
// six-slot pressed list, report sent only on change.
// ----------------------------------------------------------------------------
// One event is taken at a time. A key event steps through accept, count
// read, count write-back and list update, then the change check; a modifier
// event walks the 8 modifier bits one per cycle through the single
// saturating counter unit, then the change check. A key event with code zero
// goes to the change check at once. The change check waits while the output
// register still holds an untaken report. The 256-entry key count memory is
// cleared by per-entry valid bits, so no clearing pass follows reset.
module hid_six_key_report_builder_unit #(
    parameter int COUNT_WIDTH = hid6_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_key_code,
    input  logic [7:0] i_modifier_mask,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_report_modifiers,
    output logic [7:0] o_report_key_a,
    output logic [7:0] o_report_key_b,
    output logic [7:0] o_report_key_c,
    output logic [7:0] o_report_key_d,
    output logic [7:0] o_report_key_e,
    output logic [7:0] o_report_key_f
);
    import hid6_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KEY   = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_mode;
    t_key                 r_code;
    logic [MOD_BITS-1:0]  r_mask;
    logic [MOD_IDX_W-1:0] r_bit, n_bit;
    logic [MOD_BITS-1:0]  r_mod_bits, n_mod_bits;
    t_cnt                 r_mod_cnt [MOD_BITS];
    logic                 w_mod_we;

    t_cnt                 r_cnt_mem [KEY_CODES];
    logic [KEY_CODES-1:0] r_cnt_vld;
    t_cnt                 r_rd_data;
    logic                 r_rd_vld;
    logic                 w_mem_we;

    t_list                w_list;
    t_list_cmd            w_cmd;
    t_list                r_last;
    logic [MOD_BITS-1:0]  r_last_mods;
    logic                 r_o_valid;
    logic                 w_load;

    logic                 w_accept;
    logic                 w_up;
    t_cnt                 w_op;
    t_cnt                 w_new;
    logic                 w_new_zero;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_up     = (r_mode == MODE_KEY_PRESS) || (r_mode == MODE_MOD_PRESS);

    // shared saturating up/down counter
    always_comb begin
        if (r_state == ST_MOD) begin
            w_op = r_mod_cnt[r_bit];
        end else begin
            w_op = r_rd_vld ? r_rd_data : '0;
        end
        if (w_up) begin
            w_new = (w_op == '1) ? w_op : w_op + t_cnt'(1);
        end else begin
            w_new = (w_op == '0) ? w_op : w_op - t_cnt'(1);
        end
        w_new_zero = (w_new == '0);
    end

    always_comb begin
        n_state    = r_state;
        n_bit      = r_bit;
        n_mod_bits = r_mod_bits;
        w_mod_we   = 1'b0;
        w_mem_we   = 1'b0;
        w_load     = 1'b0;
        w_cmd      = '0;
        w_cmd.code = r_code;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_bit = '0;
                    if (i_mode == MODE_KEY_PRESS || i_mode == MODE_KEY_RELEASE) begin
                        n_state = (i_key_code == '0) ? ST_CHECK : ST_KEY;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_KEY: begin
                w_mem_we     = 1'b1;
                w_cmd.press  = (r_mode == MODE_KEY_PRESS);
                w_cmd.remove = (r_mode == MODE_KEY_RELEASE) && w_new_zero;
                n_state      = ST_CHECK;
            end
            ST_MOD: begin
                if (r_mask[r_bit]) begin
                    w_mod_we = 1'b1;
                    if (w_up) begin
                        n_mod_bits[r_bit] = 1'b1;
                    end else if (w_new_zero) begin
                        n_mod_bits[r_bit] = 1'b0;
                    end
                end
                if (r_bit == MOD_IDX_W'(MOD_BITS - 1)) begin
                    n_state = ST_CHECK;
                end else begin
                    n_bit = r_bit + MOD_IDX_W'(1);
                end
            end
            ST_CHECK: begin
                if (w_list == r_last && r_mod_bits == r_last_mods) begin
                    n_state = ST_IDLE;
                end else if (!r_o_valid || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    hid6_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_list  (w_list)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_mod_bits  <= '0;
            r_cnt_vld   <= '0;
            r_o_valid   <= 1'b0;
            r_last      <= '0;
            r_last_mods <= '0;
            for (int i = 0; i < MOD_BITS; i++) begin
                r_mod_cnt[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_bit      <= n_bit;
            r_mod_bits <= n_mod_bits;
            if (w_mod_we) begin
                r_mod_cnt[r_bit] <= w_new;
            end
            if (w_mem_we) begin
                r_cnt_vld[r_code] <= 1'b1;
            end
            // output register doubles as the last sent report
            if (w_load) begin
                r_o_valid   <= 1'b1;
                r_last      <= w_list;
                r_last_mods <= r_mod_bits;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // event beat capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_code <= i_key_code;
            r_mask <= i_modifier_mask;
        end
    end

    // key count memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_cnt_mem[r_code] <= w_new;
        end
        if (w_accept) begin
            r_rd_data <= r_cnt_mem[i_key_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_vld <= r_cnt_vld[i_key_code];
        end
    end

    assign o_valid            = r_o_valid;
    assign o_report_modifiers = r_last_mods;
    assign o_report_key_a     = r_last[0];
    assign o_report_key_b     = r_last[1];
    assign o_report_key_c     = r_last[2];
    assign o_report_key_d     = r_last[3];
    assign o_report_key_e     = r_last[4];
    assign o_report_key_f     = r_last[5];

endmodule
